>>> rtl/alsp_pkg.sv
// ----------------------------------------------------------------------------
// alsp_pkg : shared types and constants of the attack/loop sample player
// Request codes, memory geometry, field widths and the reciprocal constants
// used by the filter and gain stages.
// ----------------------------------------------------------------------------
`default_nettype none

package alsp_pkg;

	// Sample memory geometry (depth must be a power of two)
	localparam int MEM_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// Field widths
	localparam int BASE_W   = 12;
	localparam int POS_W    = 13;
	localparam int LOOPS_W  = 31;
	localparam int SAMPLE_W = 16;
	localparam int AUDIO_W  = 19;

	// base + offset never exceeds 14 bits; widen to the address if that is larger
	localparam int SUM_W  = 14;
	localparam int AEXT_W = (ADDR_W > SUM_W) ? ADDR_W : SUM_W;

	localparam logic [LOOPS_W-1:0] LOOP_FOREVER = 31'h4000_0000;

	// Stream widths
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 24;

	// x/3 for x < 2^17: (x * 43691) >> 17
	localparam logic [15:0] RECIP3    = 16'd43691;
	localparam int          RECIP3_SH = 17;
	// x/5 for x < 2^22: (x * 838861) >> 22
	localparam logic [19:0] RECIP5    = 20'd838861;
	localparam int          RECIP5_SH = 22;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_START = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	// Per-tick control travelling down the filter pipe
	typedef struct packed {
		logic en;       // block enabled at this tick
		logic zero;     // no memory read, sample is silence
		logic idle;     // status after the tick
		logic looping;  // status after the tick
	} tick_info_t;

endpackage

`default_nettype wire

>>> rtl/alsp_sample_ram.sv
// ----------------------------------------------------------------------------
// alsp_sample_ram : simple dual-port sample RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_sample_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/alsp_ctrl.sv
// ----------------------------------------------------------------------------
// alsp_ctrl : playback sequencer
// Holds the play state, decodes requests, drives the sample RAM ports and
// hands per-tick control to the filter pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_ctrl (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  acc,
	input  var  alsp_pkg::req_t                        req,
	input  wire logic        [alsp_pkg::BASE_W-1:0]    mem_addr,
	input  wire logic signed [alsp_pkg::SAMPLE_W-1:0]  sample_word,
	input  wire logic        [alsp_pkg::BASE_W-1:0]    attack_start,
	input  wire logic        [alsp_pkg::POS_W-1:0]     attack_len,
	input  wire logic                                  has_attack,
	input  wire logic        [alsp_pkg::BASE_W-1:0]    loop_start,
	input  wire logic        [alsp_pkg::POS_W-1:0]     loop_len,
	input  wire logic                                  has_loop,
	input  wire logic        [alsp_pkg::LOOPS_W-1:0]   loop_count,
	output logic                                       wr_en,
	output logic             [alsp_pkg::ADDR_W-1:0]    wr_addr,
	output logic             [alsp_pkg::SAMPLE_W-1:0]  wr_data,
	output logic                                       rd_en,
	output logic             [alsp_pkg::ADDR_W-1:0]    rd_addr,
	output alsp_pkg::tick_info_t                       tick_info
);

	logic                          enabled_q, enabled_d;
	logic                          in_attack_q, in_attack_d;
	logic [alsp_pkg::POS_W-1:0]    pos_q, pos_d;
	logic [alsp_pkg::LOOPS_W-1:0]  loops_q, loops_d;
	logic [alsp_pkg::BASE_W-1:0]   attack_base_q, attack_base_d;
	logic [alsp_pkg::POS_W-1:0]    attack_size_q, attack_size_d;
	logic [alsp_pkg::BASE_W-1:0]   loop_base_q, loop_base_d;
	logic [alsp_pkg::POS_W-1:0]    loop_size_q, loop_size_d;

	logic                          tick;
	logic                          play_loop;
	logic                          reading;
	logic                          wrap;
	logic [alsp_pkg::POS_W-1:0]    pos_inc;
	logic [alsp_pkg::BASE_W-1:0]   base_sel;
	logic [alsp_pkg::POS_W-1:0]    size_sel;
	logic [alsp_pkg::AEXT_W-1:0]   rd_sum;
	logic [alsp_pkg::AEXT_W-1:0]   wr_ext;
	logic                          st_has_l;
	logic [alsp_pkg::POS_W-1:0]    st_l_len;
	logic [alsp_pkg::BASE_W-1:0]   st_a_base;
	logic [alsp_pkg::POS_W-1:0]    st_a_len;

	assign tick      = acc && (req == alsp_pkg::REQ_TICK);
	assign play_loop = !in_attack_q && (loops_q != '0) && (loop_size_q != '0);
	assign reading   = enabled_q && (in_attack_q || play_loop);
	assign pos_inc   = pos_q + 1'b1;
	assign base_sel  = in_attack_q ? attack_base_q : loop_base_q;
	assign size_sel  = in_attack_q ? attack_size_q : loop_size_q;
	assign wrap      = pos_inc >= size_sel;

	// address wraps modulo the memory depth
	assign rd_sum  = alsp_pkg::AEXT_W'(base_sel) + alsp_pkg::AEXT_W'(pos_q);
	assign rd_addr = rd_sum[alsp_pkg::ADDR_W-1:0];
	assign rd_en   = tick && reading;

	assign wr_ext  = alsp_pkg::AEXT_W'(mem_addr);
	assign wr_addr = wr_ext[alsp_pkg::ADDR_W-1:0];
	assign wr_data = sample_word;
	assign wr_en   = acc && (req == alsp_pkg::REQ_LOAD);

	// start: a zero-length loop counts as no loop; no attack means loop as attack
	assign st_has_l  = has_loop && (loop_len != '0);
	assign st_l_len  = st_has_l ? loop_len : '0;
	assign st_a_base = has_attack ? attack_start : loop_start;
	assign st_a_len  = has_attack ? attack_len : st_l_len;

	always_comb begin
		enabled_d     = enabled_q;
		in_attack_d   = in_attack_q;
		pos_d         = pos_q;
		loops_d       = loops_q;
		attack_base_d = attack_base_q;
		attack_size_d = attack_size_q;
		loop_base_d   = loop_base_q;
		loop_size_d   = loop_size_q;
		if (acc) begin
			unique case (req)
				alsp_pkg::REQ_TICK: begin
					if (reading) begin
						pos_d = wrap ? '0 : pos_inc;
						if (wrap) begin
							if (in_attack_q) begin
								in_attack_d = 1'b0;
							end else begin
								loops_d = loops_q - 1'b1;
								if (loops_q == alsp_pkg::LOOPS_W'(1)) begin
									enabled_d = 1'b0;
								end
							end
						end
					end
				end
				alsp_pkg::REQ_LOAD: begin
				end
				alsp_pkg::REQ_START: begin
					enabled_d = st_a_len != '0;
					if (st_a_len != '0) begin
						attack_base_d = st_a_base;
						attack_size_d = st_a_len;
						loop_base_d   = loop_start;
						loop_size_d   = st_l_len;
						in_attack_d   = 1'b1;
						pos_d         = '0;
						loops_d       = st_has_l ? alsp_pkg::LOOP_FOREVER : '0;
					end
				end
				alsp_pkg::REQ_STOP: begin
					loops_d = loop_count;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		tick_info.en      = enabled_q;
		tick_info.zero    = !reading;
		tick_info.idle    = !enabled_d;
		tick_info.looping = !in_attack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			in_attack_q   <= 1'b0;
			pos_q         <= '0;
			loops_q       <= '0;
			attack_base_q <= '0;
			attack_size_q <= '0;
			loop_base_q   <= '0;
			loop_size_q   <= '0;
		end else begin
			enabled_q     <= enabled_d;
			in_attack_q   <= in_attack_d;
			pos_q         <= pos_d;
			loops_q       <= loops_d;
			attack_base_q <= attack_base_d;
			attack_size_q <= attack_size_d;
			loop_base_q   <= loop_base_d;
			loop_size_q   <= loop_size_d;
		end
	end

	// attack phase is only ever entered with a non-empty region
	a_attack_size: assert property (@(posedge clk) disable iff (!arst_n)
		in_attack_q |-> (attack_size_q != '0))
		else $error("attack phase with empty region");

	a_attack_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_attack_q |-> (pos_q < attack_size_q))
		else $error("play position beyond attack region");

	a_last_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && reading && play_loop && wrap && (loops_q == alsp_pkg::LOOPS_W'(1)))
		|=> !enabled_q)
		else $error("final loop pass did not disable playback");

endmodule

`default_nettype wire

>>> rtl/alsp_filter.sv
// ----------------------------------------------------------------------------
// alsp_filter : one-pole lowpass, gain and output register
// S1 holds RAM data and updates the level, S2 applies the 5.4 gain,
// the output register parts the pipe from the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_filter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  tick_acc,
	input  var  alsp_pkg::tick_info_t                  tick_info,
	input  wire logic signed [alsp_pkg::SAMPLE_W-1:0]  rd_data,
	output logic                                       ready,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed      [alsp_pkg::AUDIO_W-1:0]   audio,
	output logic                                       idle,
	output logic                                       looping
);

	logic                                   v_s1, v_s2;
	alsp_pkg::tick_info_t                   info_s1, info_s2;
	logic signed [alsp_pkg::SAMPLE_W-1:0]   level_q;
	logic signed [alsp_pkg::SAMPLE_W-1:0]   level_s2;
	logic                                   ready_out, ready2;

	// S1 signals
	logic signed [alsp_pkg::SAMPLE_W-1:0]   samp;
	logic signed [16:0]                     diff;
	logic signed [17:0]                     twice;
	logic        [17:0]                     twice_neg;
	logic        [16:0]                     mag3;
	logic        [32:0]                     prod3;
	logic        [15:0]                     q3;
	logic signed [16:0]                     step;
	logic signed [16:0]                     lsum;
	logic signed [alsp_pkg::SAMPLE_W-1:0]   level_new;

	// S2 signals
	logic signed [20:0]                     p27;
	logic        [20:0]                     p27_neg;
	logic        [19:0]                     mag27;
	logic        [39:0]                     prod5;
	logic        [17:0]                     q5;
	logic signed [alsp_pkg::AUDIO_W-1:0]    gain_val;

	assign ready_out = !out_valid || out_ready;
	assign ready2    = !v_s2 || ready_out;
	assign ready     = !v_s1 || ready2;

	// level += trunc(2*(s-level)/3), sign-magnitude divide by reciprocal
	assign samp      = info_s1.zero ? '0 : rd_data;
	assign diff      = 17'(samp) - 17'(level_q);
	assign twice     = {diff, 1'b0};
	assign twice_neg = -twice;
	assign mag3      = twice[17] ? twice_neg[16:0] : twice[16:0];
	assign prod3     = 33'(mag3) * 33'(alsp_pkg::RECIP3);
	assign q3        = prod3[alsp_pkg::RECIP3_SH +: 16];
	assign step      = twice[17] ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
	assign lsum      = 17'(level_q) + step;
	assign level_new = lsum[alsp_pkg::SAMPLE_W-1:0];

	// trunc(54*level/10) = trunc(27*level/5)
	assign p27      = (21'(level_s2) <<< 5) - (21'(level_s2) <<< 2) - 21'(level_s2);
	assign p27_neg  = -p27;
	assign mag27    = p27[20] ? p27_neg[19:0] : p27[19:0];
	assign prod5    = 40'(mag27) * 40'(alsp_pkg::RECIP5);
	assign q5       = prod5[alsp_pkg::RECIP5_SH +: 18];
	assign gain_val = !info_s2.en ? '0 :
	                  p27[20]     ? -$signed({1'b0, q5}) : $signed({1'b0, q5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
			level_q   <= '0;
		end else begin
			if (ready) begin
				v_s1 <= tick_acc;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (ready_out) begin
				out_valid <= v_s2;
			end
			if (v_s1 && ready2 && info_s1.en) begin
				level_q <= level_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			info_s1 <= tick_info;
		end
		if (ready2 && v_s1) begin
			info_s2  <= info_s1;
			level_s2 <= level_new;
		end
		if (ready_out && v_s2) begin
			audio   <= gain_val;
			idle    <= info_s2.idle;
			looping <= info_s2.looping;
		end
	end

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ready2 && !info_s1.en) |=> $stable(level_q))
		else $error("disabled tick changed the filter level");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> (v_s1 && v_s2 && out_valid))
		else $error("input stalled with a free pipe stage");

	a_silent_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_out && v_s2 && !info_s2.en) |=> (audio == '0))
		else $error("disabled tick gave a non-zero result");

endmodule

`default_nettype wire

>>> rtl/attack_loop_sample_player.sv
// ----------------------------------------------------------------------------
// attack_loop_sample_player : looping sample player with lowpass and gain
// Top level: stream ports, request decode, sample RAM, sequencer, filter.
// ----------------------------------------------------------------------------
// One request beat is taken per clock while the pipe has room; a stalled
// result holds in the output register while up to two more ticks fill S1 and
// S2, after which s_tready drops. Loads, starts and stops give no result. A
// tick gives one result beat, registered in turn through the RAM read with
// the filter update (S1), the gain (S2) and the output register. The rate is
// set by the single read port of the sample RAM and by the filter recurrence,
// which closes within S1. A load takes effect for a tick in the very next
// beat. Reading a RAM entry never loaded gives an undefined sample.
// ----------------------------------------------------------------------------
`default_nettype none

module attack_loop_sample_player (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [11:0] mem_addr, [27:12] sample_word, [39:28] attack_start,
	// [52:40] attack_len, [53] has_attack, [65:54] loop_start,
	// [78:66] loop_len, [79] has_loop, [110:80] loop_count, [111] zero
	input  wire logic [alsp_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]                      s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [18:0] audio_out, [19] idle, [20] looping, [23:21] zero
	output logic [alsp_pkg::M_TDATA_W-1:0]       m_tdata
);

	alsp_pkg::req_t        req;
	logic                  acc;
	logic                  tick_acc;
	alsp_pkg::tick_info_t  tick_info;

	logic                                  wr_en, rd_en;
	logic [alsp_pkg::ADDR_W-1:0]           wr_addr, rd_addr;
	logic [alsp_pkg::SAMPLE_W-1:0]         wr_data, rd_data;

	logic signed [alsp_pkg::AUDIO_W-1:0]   audio;
	logic                                  idle, looping;

	assign req      = alsp_pkg::req_t'(s_tuser);
	assign acc      = s_tvalid && s_tready;
	assign tick_acc = acc && (req == alsp_pkg::REQ_TICK);

	alsp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.req          (req),
		.mem_addr     (s_tdata[11:0]),
		.sample_word  (s_tdata[27:12]),
		.attack_start (s_tdata[39:28]),
		.attack_len   (s_tdata[52:40]),
		.has_attack   (s_tdata[53]),
		.loop_start   (s_tdata[65:54]),
		.loop_len     (s_tdata[78:66]),
		.has_loop     (s_tdata[79]),
		.loop_count   (s_tdata[110:80]),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.tick_info    (tick_info)
	);

	alsp_sample_ram #(
		.DEPTH (alsp_pkg::MEM_DEPTH),
		.WIDTH (alsp_pkg::SAMPLE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	alsp_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_acc  (tick_acc),
		.tick_info (tick_info),
		.rd_data   ($signed(rd_data)),
		.ready     (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.audio     (audio),
		.idle      (idle),
		.looping   (looping)
	);

	assign m_tdata = {3'b000, looping, idle, audio};

endmodule

`default_nettype wire
